@@ rtl/mtoh_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// Motion-triggered output hold: shared definitions
// Field widths, codes, pin mask and the beat types passed between stages.
// -----------------------------------------------------------------------------
package mtoh_pkg;

   localparam int unsigned NUM_INPUTS  = 4;
   localparam int unsigned PIN_W       = 4;
   localparam int unsigned OP_W        = 2;
   localparam int unsigned MS_W        = 32;
   localparam int unsigned MODE_W      = 2;
   localparam int unsigned CSR_IDX_W   = 2;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam int unsigned REQ_DATA_W  = 40;
   localparam int unsigned RSP_DATA_W  = 40;

   localparam logic [MS_W-1:0] MIN_HOLD_MS   = 32'd1000;
   localparam logic [MS_W-1:0] MAX_HOLD_MS   = 32'd3600000;
   localparam logic [MS_W-1:0] RESET_HOLD_MS = 32'd60000;

   localparam logic [PIN_W-1:0] PIN_MASK = (NUM_INPUTS >= PIN_W) ? {PIN_W{1'b1}} :
      PIN_W'((32'd1 << NUM_INPUTS) - 32'd1);

   localparam logic [OP_W-1:0] OP_CHECK     = 2'd0;
   localparam logic [OP_W-1:0] OP_READ      = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR_TLM = 2'd2;

   localparam logic [MODE_W-1:0] MODE_OFF    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ON     = 2'd1;
   localparam logic [MODE_W-1:0] MODE_MOTION = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_MODE          = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HOLD_MS       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MULTI_TRIGGER = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_HAS_OUTPUTS   = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]  operation;
      logic [MS_W-1:0]  now_ms;
      logic [PIN_W-1:0] motion_pins;
   } req_type;

   typedef struct packed {
      logic            output_on;
      logic            motion_report;
      logic            telemetry_motion;
      logic [MS_W-1:0] hold_left_ms;
   } rsp_type;

endpackage
`default_nettype wire

@@ rtl/mtoh_in_reg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// Motion-triggered output hold: input register
// Holds one request beat until the core and result register can take it.
// -----------------------------------------------------------------------------
module mtoh_in_reg (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output      logic             in_ready,
   input  wire mtoh_pkg::req_type in_data,
   output      logic             out_valid,
   input  wire logic             out_ready,
   output      mtoh_pkg::req_type out_data
);
   import mtoh_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   req_type data_ff;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;
   assign valid_in  = in_valid || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= in_data;
      end
   end

endmodule
`default_nettype wire

@@ rtl/mtoh_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// Motion-triggered output hold: control core
// Configuration registers, sticky flags, hold timer state and result logic.
// -----------------------------------------------------------------------------
module mtoh_core (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               step,
   input  wire mtoh_pkg::req_type                  req,
   input  wire logic                               csr_write,
   input  wire logic [mtoh_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [mtoh_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output      mtoh_pkg::rsp_type                  rsp
);
   import mtoh_pkg::*;

   function automatic logic [MS_W-1:0] clamp_hold(input logic [MS_W-1:0] v);
      logic [MS_W-1:0] r;
      r = v;
      if (v < MIN_HOLD_MS) begin
         r = MIN_HOLD_MS;
      end else if (v > MAX_HOLD_MS) begin
         r = MAX_HOLD_MS;
      end
      return r;
   endfunction

   logic [MODE_W-1:0] mode_ff;
   logic [MS_W-1:0]   hold_ms_ff;
   logic              multi_ff;
   logic              has_out_ff;

   logic              disp_ff, disp_in;
   logic              tlm_ff, tlm_in;
   logic              last_ff, last_in;
   logic [MS_W-1:0]   stamp_ff, stamp_in;
   logic              level_ff, level_in;

   logic              motion;
   logic              report;
   logic              active;
   logic              in_hold;
   logic [MS_W-1:0]   elapsed;
   logic [MS_W-1:0]   left_elapsed;
   logic [MS_W-1:0]   hold_left;
   logic [MODE_W-1:0] new_mode;

   assign new_mode = csr_wdata[MODE_W-1:0];

   always_comb begin
      motion       = |(req.motion_pins & PIN_MASK);
      disp_in      = disp_ff;
      tlm_in       = tlm_ff;
      last_in      = last_ff;
      stamp_in     = stamp_ff;
      level_in     = level_ff;
      report       = 1'b0;
      elapsed      = req.now_ms - stamp_ff;
      active       = (stamp_ff != '0);
      in_hold      = active && (elapsed < hold_ms_ff) && (elapsed != '0);
      case (req.operation)
         OP_CHECK: begin
            if (motion) begin
               disp_in = 1'b1;
               tlm_in  = 1'b1;
            end
            if ((mode_ff == MODE_MOTION) && has_out_ff) begin
               if (active && motion && multi_ff) begin
                  stamp_in = req.now_ms;
               end
               if (!in_hold && (motion != last_ff)) begin
                  last_in  = motion;
                  level_in = motion;
                  stamp_in = motion ? req.now_ms : '0;
               end
            end
         end
         OP_READ: begin
            report  = disp_ff || motion;
            disp_in = 1'b0;
         end
         OP_CLEAR_TLM: begin
            tlm_in = 1'b0;
         end
         default: begin
         end
      endcase
      left_elapsed = req.now_ms - stamp_in;
      if ((stamp_in != '0) && (hold_ms_ff > left_elapsed)) begin
         hold_left = hold_ms_ff - left_elapsed;
      end else begin
         hold_left = '0;
      end
      rsp.output_on        = level_in;
      rsp.motion_report    = report;
      rsp.telemetry_motion = tlm_in;
      rsp.hold_left_ms     = hold_left;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_MOTION;
         hold_ms_ff <= RESET_HOLD_MS;
         multi_ff   <= 1'b0;
         has_out_ff <= 1'b1;
         disp_ff    <= 1'b0;
         tlm_ff     <= 1'b0;
         last_ff    <= 1'b0;
         stamp_ff   <= '0;
         level_ff   <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            REG_MODE: begin
               mode_ff  <= new_mode;
               stamp_ff <= '0;
               last_ff  <= 1'b0;
               level_ff <= (new_mode != MODE_OFF) && (new_mode != MODE_MOTION);
            end
            REG_HOLD_MS: begin
               hold_ms_ff <= clamp_hold(csr_wdata[MS_W-1:0]);
            end
            REG_MULTI_TRIGGER: begin
               multi_ff <= csr_wdata[0];
            end
            REG_HAS_OUTPUTS: begin
               has_out_ff <= csr_wdata[0];
            end
            default: begin
            end
         endcase
      end else if (step) begin
         disp_ff  <= disp_in;
         tlm_ff   <= tlm_in;
         last_ff  <= last_in;
         stamp_ff <= stamp_in;
         level_ff <= level_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/mtoh_out_reg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// Motion-triggered output hold: result register
// Holds one result beat; takes a new one whenever the slot is free or draining.
// -----------------------------------------------------------------------------
module mtoh_out_reg (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output      logic              in_ready,
   input  wire mtoh_pkg::rsp_type in_data,
   output      logic              out_valid,
   input  wire logic              out_ready,
   output      mtoh_pkg::rsp_type out_data
);
   import mtoh_pkg::*;

   logic    valid_ff;
   rsp_type data_ff;

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= in_data;
      end
   end

endmodule
`default_nettype wire

@@ rtl/motion_triggered_output_hold_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// Motion-triggered output hold controller
// Checks motion pins, keeps sticky display and telemetry flags, and drives an
// output that is held for a programmable time after a motion edge.
//
//   Channel  Direction  Beat contents
//   req      in         tdata: now_ms, motion_pins; tuser: operation
//   rsp      out        tdata: output_on, motion_report, telemetry_motion,
//                       hold_left_ms
//   csr      in         csr_index selects the register, csr_wdata is the value
//
// One beat is accepted per cycle unless the result slot stalls. The core does the
// state update and remaining-time subtraction combinationally between the input
// and result registers. Reset is synchronous and restores the register defaults.
// A stalled result slot stalls the input register, which then stalls req.
// -----------------------------------------------------------------------------
module motion_triggered_output_hold_top (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output      logic                             req_tready,
   // [31:0] now_ms, [35:32] motion_pins, [39:36] zero
   input  wire logic [mtoh_pkg::REQ_DATA_W-1:0]  req_tdata,
   // [1:0] operation
   input  wire logic [mtoh_pkg::OP_W-1:0]        req_tuser,
   output      logic                             rsp_tvalid,
   input  wire logic                             rsp_tready,
   // [0] output_on, [1] motion_report, [2] telemetry_motion,
   // [34:3] hold_left_ms, [39:35] zero
   output      logic [mtoh_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  wire logic                             csr_valid,
   output      logic                             csr_ready,
   input  wire logic [mtoh_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [mtoh_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import mtoh_pkg::*;

   req_type in_beat;
   req_type core_req;
   rsp_type core_rsp;
   rsp_type out_beat;
   logic    core_valid;
   logic    core_ready;

   assign in_beat.operation   = req_tuser;
   assign in_beat.now_ms      = req_tdata[MS_W-1:0];
   assign in_beat.motion_pins = req_tdata[MS_W+PIN_W-1:MS_W];

   assign csr_ready = 1'b1;

   mtoh_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (in_beat),
      .out_valid (core_valid),
      .out_ready (core_ready),
      .out_data  (core_req)
   );

   mtoh_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (core_valid && core_ready),
      .req       (core_req),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp       (core_rsp)
   );

   mtoh_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (core_valid),
      .in_ready  (core_ready),
      .in_data   (core_rsp),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_beat)
   );

   assign rsp_tdata = {5'd0, out_beat.hold_left_ms, out_beat.telemetry_motion,
                       out_beat.motion_report, out_beat.output_on};

endmodule
`default_nettype wire

@@ verif/motion_triggered_output_hold_top_tb.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Motion-triggered output hold controller: self-checking testbench
// A queue of request beats feeds a driver that idles at random. A monitor
// predicts every result from its own model of the flags, the hold timer and
// the registers. It compares each result beat field by field with the oldest
// prediction. Registers are rewritten between phases while the block is idle.
// -----------------------------------------------------------------------------
module motion_triggered_output_hold_top_tb;
   import mtoh_pkg::*;

   localparam logic [OP_W-1:0]   OP_SPARE    = 2'd3;
   localparam logic [MODE_W-1:0] MODE_SPARE  = 2'd3;
   localparam int                STALL_LIMIT = 5000;
   localparam int                PHASE_ITEMS = 115;

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata  = '0;
   logic [OP_W-1:0]         req_tuser  = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    csr_valid  = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index  = '0;
   logic [CSR_DATA_W-1:0]   csr_wdata  = '0;

   motion_triggered_output_hold_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   // Predicted controller registers and state.
   logic [MODE_W-1:0] cfg_mode;
   logic [MS_W-1:0]   cfg_hold;
   logic              cfg_multi;
   logic              cfg_outputs;
   logic              disp_seen;
   logic              tlm_seen;
   logic              motion_was;
   logic [MS_W-1:0]   hold_stamp;
   logic              out_level;

   req_type pending_req_q[$];
   rsp_type due_rsp_q[$];

   int fail_count = 0;
   int req_taken  = 0;
   int idle_cycles = 0;
   bit req_fired  = 1'b0;

   int src_wait  = 0;
   int src_calm  = 0;
   int sink_wait = 0;
   int sink_calm = 0;
   bit sink_holdoff_done = 1'b0;

   logic [MS_W-1:0] gen_now    = '0;
   logic [MS_W-1:0] gen_anchor = '0;
   logic [MS_W-1:0] gen_span   = RESET_HOLD_MS;
   logic            gen_level  = 1'b0;

   function automatic logic [MS_W-1:0] clamp_hold_time(logic [MS_W-1:0] v);
      if (v < MIN_HOLD_MS) return MIN_HOLD_MS;
      if (v > MAX_HOLD_MS) return MAX_HOLD_MS;
      return v;
   endfunction

   function automatic void apply_reg_write(logic [CSR_IDX_W-1:0] idx,
                                           logic [CSR_DATA_W-1:0] data);
      case (idx)
         REG_MODE: begin
            cfg_mode   = data[MODE_W-1:0];
            hold_stamp = '0;
            motion_was = 1'b0;
            out_level  = (cfg_mode != MODE_OFF) && (cfg_mode != MODE_MOTION);
         end
         REG_HOLD_MS:       cfg_hold    = clamp_hold_time(data);
         REG_MULTI_TRIGGER: cfg_multi   = data[0];
         REG_HAS_OUTPUTS:   cfg_outputs = data[0];
         default: ;
      endcase
   endfunction

   function automatic rsp_type hold_step(req_type beat);
      rsp_type         r;
      logic            motion;
      logic            active;
      logic [MS_W-1:0] d;
      r = '0;
      motion = (beat.motion_pins & PIN_MASK) != '0;
      case (beat.operation)
         OP_CHECK: begin
            if (motion) begin
               disp_seen = 1'b1;
               tlm_seen  = 1'b1;
            end
            if (cfg_mode == MODE_MOTION && cfg_outputs) begin
               d = beat.now_ms - hold_stamp;
               active = hold_stamp != '0;
               if (active && motion && cfg_multi) hold_stamp = beat.now_ms;
               if (!(active && d < cfg_hold && d != '0) && motion != motion_was) begin
                  motion_was = motion;
                  hold_stamp = motion ? beat.now_ms : '0;
                  out_level  = motion;
               end
            end
         end
         OP_READ: begin
            r.motion_report = disp_seen | motion;
            disp_seen = 1'b0;
         end
         OP_CLEAR_TLM: tlm_seen = 1'b0;
         default: ;
      endcase
      if (hold_stamp != '0) begin
         d = beat.now_ms - hold_stamp;
         r.hold_left_ms = (cfg_hold > d) ? cfg_hold - d : '0;
      end
      r.output_on        = out_level;
      r.telemetry_motion = tlm_seen;
      return r;
   endfunction

   function automatic void check_field(string name, logic [MS_W-1:0] want,
                                       logic [MS_W-1:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   // Mostly short gaps, a few long ones, and now and then a calm stretch.
   function automatic int idle_len(ref int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 2) begin
         calm = $urandom_range(20, 60);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [CSR_DATA_W-1:0] with_junk(logic [CSR_DATA_W-1:0] v,
                                                      logic [CSR_DATA_W-1:0] used);
      return ($urandom_range(0, 1) ? ($urandom & ~used) : '0) | (v & used);
   endfunction

   always @(negedge clock) begin
      req_type beat;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_fired) begin
         // The beat on the bus has not been taken yet.
      end else if (src_wait > 0) begin
         src_wait--;
         req_tvalid <= 1'b0;
      end else if (pending_req_q.size() != 0) begin
         beat = pending_req_q.pop_front();
         req_tdata  <= {4'b0, beat.motion_pins, beat.now_ms};
         req_tuser  <= beat.operation;
         req_tvalid <= 1'b1;
         src_wait = idle_len(src_calm);
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // The receiver holds off once for a long stretch so that the block backs up.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (!sink_holdoff_done && req_taken >= 500) begin
         sink_holdoff_done = 1'b1;
         sink_wait = 400;
         rsp_tready <= 1'b0;
      end else if (sink_wait > 0) begin
         sink_wait--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         sink_wait = idle_len(sink_calm);
      end
   end

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      req_type beat;
      if (reset) begin
         cfg_hold    = RESET_HOLD_MS;
         cfg_multi   = 1'b0;
         cfg_outputs = 1'b1;
         disp_seen   = 1'b0;
         tlm_seen    = 1'b0;
         apply_reg_write(REG_MODE, CSR_DATA_W'(MODE_MOTION));
         req_fired <= 1'b0;
      end else begin
         req_fired <= req_tvalid && req_tready;
         if (rsp_tvalid && rsp_tready) begin
            got.output_on        = rsp_tdata[0];
            got.motion_report    = rsp_tdata[1];
            got.telemetry_motion = rsp_tdata[2];
            got.hold_left_ms     = rsp_tdata[34:3];
            if (due_rsp_q.size() == 0) begin
               $error("Result beat arrived with no result expected.");
               fail_count++;
            end else begin
               want = due_rsp_q.pop_front();
               check_field("output_on", MS_W'(want.output_on), MS_W'(got.output_on));
               check_field("motion_report", MS_W'(want.motion_report),
                           MS_W'(got.motion_report));
               check_field("telemetry_motion", MS_W'(want.telemetry_motion),
                           MS_W'(got.telemetry_motion));
               check_field("hold_left_ms", want.hold_left_ms, got.hold_left_ms);
            end
         end
         if (csr_valid && csr_ready) apply_reg_write(csr_index, csr_wdata);
         if (req_tvalid && req_tready) begin
            beat.operation   = req_tuser;
            beat.now_ms      = req_tdata[31:0];
            beat.motion_pins = req_tdata[35:32];
            due_rsp_q.push_back(hold_step(beat));
            req_taken++;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic push_req(logic [OP_W-1:0] op, logic [MS_W-1:0] now,
                           logic [PIN_W-1:0] pins);
      req_type beat;
      beat.operation   = op;
      beat.now_ms      = now;
      beat.motion_pins = pins;
      pending_req_q.push_back(beat);
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (pending_req_q.size() != 0 || req_tvalid || due_rsp_q.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_index <= idx;
      csr_wdata <= data;
      csr_valid <= 1'b1;
      do @(posedge clock);
      while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Motion runs with timestamps that land short of, on and past the hold
   // window, plus some noise beats with fully random content.
   task automatic run_phase(bit set_mode, logic [MODE_W-1:0] mode_val,
                            logic [MS_W-1:0] hold_val, bit multi, bit outputs);
      int              r;
      logic            prev_level;
      logic [OP_W-1:0] op;
      logic [PIN_W-1:0] pins;
      wait_drained();
      write_reg(REG_HOLD_MS, hold_val);
      write_reg(REG_MULTI_TRIGGER, with_junk(CSR_DATA_W'(multi), 32'h1));
      write_reg(REG_HAS_OUTPUTS, with_junk(CSR_DATA_W'(outputs), 32'h1));
      if (set_mode) write_reg(REG_MODE, with_junk(CSR_DATA_W'(mode_val), 32'h3));
      gen_span = clamp_hold_time(hold_val);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
         if ($urandom_range(0, 99) < 10) begin
            push_req(OP_W'($urandom_range(0, 3)), $urandom, PIN_W'($urandom_range(0, 15)));
         end else begin
            r = $urandom_range(0, 99);
            if (r < 25)      gen_now = gen_now;
            else if (r < 55) gen_now = gen_now + $urandom_range(1, gen_span / 4 + 1);
            else if (r < 70) gen_now = gen_anchor + gen_span + $urandom_range(0, 2) - 1;
            else if (r < 82) gen_now = gen_now + $urandom_range(gen_span / 2, 2 * gen_span);
            else if (r < 85) gen_now = '0;
            else if (r < 89) gen_now = 32'hFFFF_FFFF - $urandom_range(0, gen_span);
            else             gen_now = $urandom;
            prev_level = gen_level;
            if ($urandom_range(0, 99) < 30) gen_level = !gen_level;
            pins = gen_level ? PIN_W'($urandom_range(1, 15)) : '0;
            if (gen_level && (!prev_level || $urandom_range(0, 1))) gen_anchor = gen_now;
            r = $urandom_range(0, 99);
            if (r < 68)      op = OP_CHECK;
            else if (r < 80) op = OP_READ;
            else if (r < 92) op = OP_CLEAR_TLM;
            else             op = OP_SPARE;
            push_req(op, gen_now, pins);
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed beats under the reset settings: motion mode, 60 s hold.
      push_req(OP_SPARE,     32'd5,          4'hF);
      push_req(OP_READ,      32'd10,         4'h0);
      push_req(OP_CHECK,     32'd0,          4'h1);
      push_req(OP_CHECK,     32'd50,         4'h0);
      push_req(OP_CHECK,     32'd1000,       4'h8);
      push_req(OP_CHECK,     32'd1000,       4'h0);
      push_req(OP_CHECK,     32'd2000,       4'h2);
      push_req(OP_CHECK,     32'd30000,      4'h0);
      push_req(OP_READ,      32'd30001,      4'h0);
      push_req(OP_READ,      32'd30002,      4'h4);
      push_req(OP_CLEAR_TLM, 32'd30003,      4'hF);
      push_req(OP_CHECK,     32'd62000,      4'h0);
      push_req(OP_CHECK,     32'hFFFF_FFF0,  4'h1);
      push_req(OP_CHECK,     32'h0000_0100,  4'h0);
      push_req(OP_CHECK,     32'hFFFF_FFFF,  4'h0);
      push_req(OP_READ,      32'h1234_5678,  4'hA);
      push_req(OP_SPARE,     32'hFFFF_FFFF,  4'h0);
      push_req(OP_CHECK,     32'h0001_0000,  4'h0);

      run_phase(1'b1, MODE_MOTION, 32'd1000,       1'b0, 1'b1);
      run_phase(1'b0, MODE_MOTION, 32'd0,          1'b1, 1'b1);
      run_phase(1'b1, MODE_MOTION, 32'hFFFF_FFFF,  1'b1, 1'b1);
      run_phase(1'b1, MODE_OFF,    32'd3000,       1'b1, 1'b1);
      run_phase(1'b1, MODE_ON,     32'd2000,       1'b0, 1'b0);
      run_phase(1'b1, MODE_SPARE,  32'd1000,       1'b1, 1'b1);
      run_phase(1'b1, MODE_MOTION, 32'd2500,       1'b1, 1'b0);
      run_phase(1'b0, MODE_MOTION, 32'd2500,       1'b1, 1'b1);
      run_phase(1'b1, MODE_MOTION, 32'd3600000,    1'b0, 1'b1);
      run_phase(1'b1, MODE_MOTION, 32'd999,        1'b1, 1'b1);
      run_phase(1'b0, MODE_MOTION, 32'd3600001,    1'b0, 1'b1);

      wait_drained();
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/mtoh_pkg.sv
rtl/mtoh_in_reg.sv
rtl/mtoh_core.sv
rtl/mtoh_out_reg.sv
rtl/motion_triggered_output_hold_top.sv
verif/motion_triggered_output_hold_top_tb.sv
